/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the sliding window median block.
// Each macro expects clk and arst_n to exist in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define SWMS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Overlapping implication: cons must hold in the cycle that ante holds.
`define SWMS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Non-overlapping implication: cons must hold in the cycle after ante.
`define SWMS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/swms_pkg.sv */
// Package for the sliding window median / mean / spread block.
// Widths, reset values and the sequencer state type; no dependencies.
`default_nettype none

package swms_pkg;

	localparam int SAMPLE_W           = 24;
	localparam int DEFAULT_WINDOW_LEN = 7;
	localparam logic [SAMPLE_W-1:0] MAXDEV_RESET = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_START,
		ST_DIV,
		ST_PUT
	} swms_state_t;

endpackage

`default_nettype wire

/* design/swms_div.sv */
// Division by a constant through multiplication by a rounded-up reciprocal.
// Start sets busy, then done; uses nothing from the package, divisor and width come from the top level.
`default_nettype none

module swms_div #(
	parameter int DIVISOR = 7,
	parameter int DW      = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);

	// Reciprocal rounded up and scaled by 2^SH; exact for every DW-bit dividend.
	localparam int LW = $clog2(DIVISOR);
	localparam int SH = DW + LW;
	localparam int MW = DW + 1;
	localparam logic [63:0] RECIP =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [MW-1:0] RECIP_C = RECIP[MW-1:0];

	logic [DW-1:0]    x_q;
	logic [DW-1:0]    quot_q;
	logic             busy_q;
	logic             done_q;
	logic [DW+MW-1:0] prod;

	assign prod = x_q * RECIP_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) x_q <= dividend;
		if (busy_q) quot_q <= DW'(prod >> SH);
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

/* design/sliding_window_median_stats.sv */
// Channel  | dir | handshake          | payload
// ---------+-----+--------------------+-------------------------------------------
// in       | in  | in_valid/in_stall  | sample_in
// out      | out | out_valid/out_stall| median_out, mean_out, mean_ready, spread_ok
// cfg      | in  | cfg_valid/cfg_ready| cfg_data (max_deviation)
//
// A request passes the idle state that accepts it, a walk over every window entry for
// rank, sum, min and max, a state that starts the mean, the reciprocal divider, and the
// put state that loads the result into the output register.
// in_stall is high from acceptance until the result is loaded into the output register.
// A result waiting under out_stall does not block the next request's acceptance; that
// request then holds in its load cycle until the output register is free.
// Reset clears the window to zero, the fill count, and sets max_deviation to all ones.
//
// Top level of the sliding window median block; uses swms_pkg, swms_div, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_median_stats #(
	parameter int WINDOW_LEN = swms_pkg::DEFAULT_WINDOW_LEN
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [swms_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [swms_pkg::SAMPLE_W-1:0] median_out,
	output logic signed [swms_pkg::SAMPLE_W-1:0] mean_out,
	output logic                                 mean_ready,
	output logic                                 spread_ok,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [swms_pkg::SAMPLE_W-1:0] cfg_data
);

	import swms_pkg::*;

	localparam int IW   = $clog2(WINDOW_LEN);
	localparam int CW   = $clog2(WINDOW_LEN + 1);
	localparam int SW   = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int RANK = (WINDOW_LEN - 1) / 2;
	localparam logic [CW-1:0] RANK_C = CW'(RANK);
	localparam logic [CW-1:0] LEN_C  = CW'(WINDOW_LEN);
	localparam logic [IW-1:0] LAST_C = IW'(WINDOW_LEN - 1);

	swms_state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] win_q [WINDOW_LEN];
	logic [CW-1:0]              fill_q;
	logic [SAMPLE_W-1:0]        maxdev_q;

	logic [IW-1:0]              idx_q;
	logic signed [SW-1:0]       sum_q;
	logic signed [SAMPLE_W-1:0] lo_q, hi_q, med_q;
	logic                       found_q;

	logic signed [SAMPLE_W-1:0] median_q, mean_q;
	logic                       ready_q, spread_q, out_valid_q;

	logic                       accept;
	logic                       walk_first, walk_last;
	logic                       div_start, div_busy, div_done, load;
	logic signed [SAMPLE_W-1:0] cand;
	logic signed [SW-1:0]       cand_ext;
	logic [WINDOW_LEN-1:0]      lt_v, le_v;
	logic [CW-1:0]              below, not_above;
	logic                       is_rank;
	logic [SW-1:0]              sum_mag;
	logic [SW-1:0]              quot;
	logic [SAMPLE_W-1:0]        quot_lo;
	logic [SAMPLE_W-1:0]        mean_val;
	logic [SAMPLE_W:0]          spread;
	logic                       full;

	assign accept     = in_valid && !in_stall;
	assign cfg_ready  = 1'b1;
	assign walk_first = (idx_q == '0);
	assign walk_last  = (idx_q == LAST_C);
	assign full       = (fill_q == LEN_C);

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_WALK;
			ST_WALK:  if (walk_last) state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_PUT;
			ST_PUT:   if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---- sequencer outputs ----
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_START: div_start = 1'b1;
			ST_PUT:   load = !out_valid_q || !out_stall;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- window, fill count, limit register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) win_q[i] <= '0;
			fill_q   <= '0;
			maxdev_q <= MAXDEV_RESET;
		end else begin
			if (cfg_valid && cfg_ready) maxdev_q <= cfg_data;
			if (accept) begin
				for (int i = 0; i < WINDOW_LEN - 1; i++) win_q[i] <= win_q[i + 1];
				win_q[WINDOW_LEN-1] <= sample_in;
				if (!full) fill_q <= fill_q + 1'b1;
			end
		end
	end

	// ---- walk: one candidate per cycle, ranked against the whole window ----
	assign cand     = win_q[idx_q];
	assign cand_ext = {{(SW - SAMPLE_W){cand[SAMPLE_W-1]}}, cand};

	always_comb begin
		for (int j = 0; j < WINDOW_LEN; j++) begin
			lt_v[j] = (win_q[j] < cand);
			le_v[j] = (win_q[j] <= cand);
		end
	end

	assign below     = CW'($countones(lt_v));
	assign not_above = CW'($countones(le_v));
	assign is_rank   = (below <= RANK_C) && (RANK_C < not_above);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_WALK) begin
				if (!walk_last) idx_q <= idx_q + 1'b1;
				if (is_rank) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK) begin
			sum_q <= walk_first ? cand_ext : sum_q + cand_ext;
			if (walk_first || cand < lo_q) lo_q <= cand;
			if (walk_first || cand > hi_q) hi_q <= cand;
			if (is_rank && !found_q) med_q <= cand;
		end
	end

	// ---- mean: magnitude through the constant divider, sign restored ----
	assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	swms_div #(
		.DIVISOR (WINDOW_LEN),
		.DW      (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot)
	);

	assign quot_lo  = quot[SAMPLE_W-1:0];
	assign mean_val = sum_q[SW-1] ? (~quot_lo + 1'b1) : quot_lo;
	assign spread   = {hi_q[SAMPLE_W-1], hi_q} - {lo_q[SAMPLE_W-1], lo_q};

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			median_q <= med_q;
			mean_q   <= full ? $signed(mean_val) : '0;
			ready_q  <= full;
			spread_q <= (spread < {1'b0, maxdev_q});
		end
	end

	assign out_valid  = out_valid_q;
	assign median_out = median_q;
	assign mean_out   = mean_q;
	assign mean_ready = ready_q;
	assign spread_ok  = spread_q;

	// ---- checks ----
	`SWMS_ASSERT_NEXT(a_accept_walk, accept, state_q == ST_WALK, "request did not start the walk")
	`SWMS_ASSERT_IMPL(a_div_done_state, div_done, state_q == ST_DIV, "divider done outside wait")
	`SWMS_ASSERT_IMPL(a_div_running, state_q == ST_DIV, div_busy || div_done, "divider idle in wait")
	`SWMS_ASSERT(a_fill_bound, fill_q <= LEN_C, "fill count beyond window length")

endmodule

`default_nettype wire

/* test/tb_sliding_window_median_stats.sv */
// Testbench for sliding_window_median_stats: median, truncated mean and spread flag
// checked against an in-bench window model. Depends on swms_pkg and the block RTL.
`default_nettype none

module tb_sliding_window_median_stats;
	timeunit 1ns;
	timeprecision 1ps;

	import swms_pkg::*;

	localparam int WLEN       = DEFAULT_WINDOW_LEN;
	localparam int MAX_CYCLES = 1_000_000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

	typedef enum int {
		SK_FULL,
		SK_NARROW,
		SK_FEW
	} sample_kind_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] median;
		logic signed [SAMPLE_W-1:0] mean;
		logic                       ready;
		logic                       spread;
	} window_stats_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] median_out;
	logic signed [SAMPLE_W-1:0] mean_out;
	logic                       mean_ready;
	logic                       spread_ok;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic        [SAMPLE_W-1:0] cfg_data  = '0;

	sliding_window_median_stats #(.WINDOW_LEN(WLEN)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.median_out(median_out),
		.mean_out  (mean_out),
		.mean_ready(mean_ready),
		.spread_ok (spread_ok),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// window model
	logic signed [SAMPLE_W-1:0] win_q [WLEN];
	int                         fill_q;
	logic        [SAMPLE_W-1:0] limit_q;

	window_stats_t expected_stats [$];
	int            errors;
	int            cycles;
	bit            send_busy;
	bit            stall_busy;
	int            stall_left;
	logic signed [SAMPLE_W-1:0] narrow_base;

	function automatic window_stats_t shift_window(logic signed [SAMPLE_W-1:0] s);
		logic signed [SAMPLE_W-1:0] sorted [WLEN];
		logic signed [SAMPLE_W-1:0] t;
		longint                     acc, lo, hi;
		int                         i, j;
		window_stats_t              r;
		for (i = 0; i < WLEN - 1; i++)
			win_q[i] = win_q[i + 1];
		win_q[WLEN - 1] = s;
		if (fill_q < WLEN)
			fill_q++;
		acc = 0;
		lo  = win_q[0];
		hi  = win_q[0];
		for (i = 0; i < WLEN; i++) begin
			acc += win_q[i];
			if (win_q[i] < lo)
				lo = win_q[i];
			if (win_q[i] > hi)
				hi = win_q[i];
			sorted[i] = win_q[i];
		end
		for (i = 1; i < WLEN; i++) begin
			t = sorted[i];
			j = i - 1;
			while (j >= 0 && sorted[j] > t) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = t;
		end
		r.median = sorted[(WLEN - 1) / 2];
		r.ready  = (fill_q >= WLEN);
		// signed longint division truncates toward zero
		r.mean   = r.ready ? SAMPLE_W'(acc / WLEN) : '0;
		r.spread = (hi - lo) < longint'(limit_q);
		return r;
	endfunction

	function automatic int idle_len(bit busy);
		int r;
		if (!busy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_kind_t kind);
		int r;
		case (kind)
			SK_NARROW: begin
				if ($urandom_range(0, 39) == 0)
					narrow_base = $signed(SAMPLE_W'($urandom_range(0, 16000000))) - 24'sd8000000;
				return narrow_base + $signed(SAMPLE_W'($urandom_range(0, 1000))) - 24'sd500;
			end
			SK_FEW: begin
				r = $urandom_range(0, 5);
				case (r)
					0: return S_MIN;
					1: return S_MAX;
					2: return -24'sd1;
					3: return 24'sd1;
					4: return 24'sd2047;
					default: return '0;
				endcase
			end
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// one request on the input channel; valid is left high for a back-to-back follow-up
	task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
		int gap;
		gap = idle_len(send_busy);
		@(negedge clk);
		if (gap > 0) begin
			in_valid  = 1'b0;
			sample_in = SAMPLE_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		sample_in = s;
		do @(posedge clk); while (in_stall);
		expected_stats.push_back(shift_window(s));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_limit(logic [SAMPLE_W-1:0] v);
		drain_results();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		limit_q = v;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = SAMPLE_W'($urandom);
	endtask

	task automatic send_random(int n, sample_kind_t kind);
		for (int i = 0; i < n; i++)
			send_sample(pick_sample(kind));
	endtask

	// zeros from reset take part until the window fills; the six requests here leave mean_ready low, it rises on the 7th
	task automatic test_unfilled_window();
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(24'sd1);
		send_sample(-24'sd1);
		send_sample(24'sh555555);
		send_sample(-24'sd3);
	endtask

	task automatic test_extreme_windows();
		repeat (7) send_sample(S_MAX);
		repeat (7) send_sample(S_MIN);
	endtask

	task automatic test_zero_limit();
		set_limit('0);
		repeat (3) send_sample(24'sd5);
		set_limit(24'd1);
		repeat (2) send_sample(24'sd5);
	endtask

	task automatic test_full_range();
		set_limit('1);
		send_random(250, SK_FULL);
	endtask

	task automatic test_narrow_spread();
		set_limit(SAMPLE_W'($urandom_range(0, 2000)));
		send_random(125, SK_NARROW);
		set_limit(SAMPLE_W'($urandom_range(300, 1200)));
		send_random(125, SK_NARROW);
	endtask

	task automatic test_repeated_values();
		set_limit(SAMPLE_W'($urandom));
		send_random(250, SK_FEW);
	endtask

	task automatic test_zero_limit_random();
		set_limit('0);
		send_random(120, SK_NARROW);
		send_random(130, SK_FEW);
	endtask

	task automatic test_drain_pause();
		set_limit(24'd1);
		send_random(60, SK_FEW);
		drain_results();
		send_random(60, SK_NARROW);
		set_limit(24'h800000);
		send_random(65, SK_FULL);
		drain_results();
		send_random(65, SK_NARROW);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (stall_busy && $urandom_range(0, 2) == 0) begin
			out_stall  = 1'b1;
			stall_left = idle_len(1'b1);
		end else begin
			out_stall  = 1'b0;
			stall_left = $urandom_range(0, 5);
		end
	end

	always @(posedge clk) begin
		window_stats_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_stats.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				e = expected_stats.pop_front();
				if (median_out !== e.median) begin
					$error("median_out expected %0d actual %0d", e.median, median_out);
					errors++;
				end
				if (mean_out !== e.mean) begin
					$error("mean_out expected %0d actual %0d", e.mean, mean_out);
					errors++;
				end
				if (mean_ready !== e.ready) begin
					$error("mean_ready expected %0b actual %0b", e.ready, mean_ready);
					errors++;
				end
				if (spread_ok !== e.spread) begin
					$error("spread_ok expected %0b actual %0b", e.spread, spread_ok);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < WLEN; i++)
			win_q[i] = '0;
		fill_q      = 0;
		limit_q     = MAXDEV_RESET;
		errors      = 0;
		cycles      = 0;
		send_busy   = 1'b0;
		stall_busy  = 1'b0;
		stall_left  = 0;
		narrow_base = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_unfilled_window();
		send_busy  = 1'b1;
		stall_busy = 1'b1;
		test_extreme_windows();
		test_zero_limit();
		send_busy  = 1'b0;
		stall_busy = 1'b0;
		test_full_range();
		send_busy  = 1'b1;
		stall_busy = 1'b1;
		test_narrow_spread();
		test_repeated_values();
		stall_busy = 1'b0;
		test_zero_limit_random();
		stall_busy = 1'b1;
		test_drain_pause();

		drain_results();
		repeat (2 * WLEN + 50) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
